// ===== design/box_blur_3x3_rgba_top_macros.svh =====
// Assertion macros for the 3x3 box blur top level.
// Needs clk and arst_n in the scope of use.
`ifndef BOX_BLUR_3X3_RGBA_TOP_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_TOP_MACROS_SVH

// consequent in the same cycle
`define BBLUR_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define BBLUR_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bblur_pkg.sv =====
// Shared constants, types and helpers of the 3x3 box blur.
// No dependencies.
`timescale 1ns / 1ps
package bblur_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int RGB_W      = 24;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;

	localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd800;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd600;
	localparam logic [DIM_W-1:0] LIMIT_WIDTH  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] LIMIT_HEIGHT = DIM_W'(MAX_HEIGHT);
	localparam logic [CH_W-1:0]  ALPHA        = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef logic [RGB_W-1:0] rgb_t;

	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
		rgb_t lower;
	} column_t;

	typedef struct packed {
		logic             adv;
		logic             emit;
		logic             eof;
		logic [COL_W-1:0] col;
		logic [2:0]       row_mask;
		logic [2:0]       col_mask;
		rgb_t             rgb;
	} issue_t;

	typedef struct packed {
		logic             valid;
		logic             eof;
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sums_t;

	// floor(s / 9) for s up to 9 * 255
	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [2*SUM_W-1:0] p;
		p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
		return p[DIV9_SHIFT +: CH_W];
	endfunction

	// 0 reads as 1, anything over the limit as the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (raw == '0)
			r = DIM_W'(1);
		else if (raw > lim)
			r = lim;
		else
			r = raw;
		return r;
	endfunction

endpackage

// ===== design/bblur_ctrl.sv =====
// Frame sequencing of the box blur: size registers, raster position, drain count.
// Issues one line-store step per cycle at most, none while en is low. Depends on bblur_pkg.
`timescale 1ns / 1ps
module bblur_ctrl import bblur_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 command,
	input  logic [31:0]          pixel_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output issue_t               iss
);

	logic [DIM_W-1:0] width_q, height_q, drain_q;
	logic [COL_W-1:0] col_q, col_nx;
	logic [ROW_W-1:0] row_q, row_nx;
	logic             phantom_q;
	logic             accept, pix_go, drn_go, ph_go, adv;
	logic             emit_last, emit_mid, wrap;
	logic [DIM_W-1:0] col_inc;
	logic [ROW_W:0]   row_sum, row_lim, row_off;

	assign item_stall = !en || phantom_q;
	assign accept     = item_valid && !item_stall;
	assign pix_go     = accept && (cmd_t'(command) == CMD_PIXEL) && (drain_q == '0);
	assign drn_go     = accept && (cmd_t'(command) == CMD_DRAIN) && (drain_q != '0);
	// one-row frames step once over the empty position before draining
	assign ph_go      = phantom_q && en;
	assign adv        = pix_go || drn_go || ph_go;

	assign emit_last = (col_q == '0) && (row_q >= ROW_W'(2));
	assign emit_mid  = (col_q != '0) && (row_q != '0);

	assign col_inc = DIM_W'(col_q) + DIM_W'(1);
	assign wrap    = col_inc >= width_q;
	assign col_nx  = wrap ? '0 : col_inc[COL_W-1:0];
	assign row_nx  = wrap ? row_q + ROW_W'(1) : row_q;

	always_comb begin
		iss.adv  = adv;
		iss.emit = adv && (emit_last || emit_mid);
		iss.eof  = drn_go && (drain_q == DIM_W'(1));
		iss.col  = col_q;
		iss.rgb  = pix_go ? pixel_in[31:8] : '0;
		row_off  = emit_last ? (ROW_W+1)'(3) : (ROW_W+1)'(2);
		row_lim  = (ROW_W+1)'(height_q) + row_off;
		row_sum  = '0;
		for (int k = 0; k < 3; k++) begin
			row_sum         = (ROW_W+1)'(row_q) + (ROW_W+1)'(k);
			iss.row_mask[k] = (row_sum >= row_off) && (row_sum < row_lim);
		end
		if (emit_last)
			iss.col_mask = {1'b0, 1'b1, width_q >= DIM_W'(2)};
		else
			iss.col_mask = {1'b1, 1'b1, col_q >= COL_W'(2)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RESET_WIDTH;
			height_q  <= RESET_HEIGHT;
			col_q     <= '0;
			row_q     <= '0;
			drain_q   <= '0;
			phantom_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= eff_dim(cfg_data, LIMIT_WIDTH);
				REG_FRAME_HEIGHT: height_q <= eff_dim(cfg_data, LIMIT_HEIGHT);
			endcase
			col_q     <= '0;
			row_q     <= '0;
			drain_q   <= '0;
			phantom_q <= 1'b0;
		end else if (adv) begin
			// last drain beat returns to the top of the frame
			col_q <= iss.eof ? '0 : col_nx;
			row_q <= iss.eof ? '0 : row_nx;
			if (pix_go && (row_nx >= ROW_W'(height_q))) begin
				drain_q   <= (height_q == DIM_W'(1)) ? width_q : width_q + DIM_W'(1);
				phantom_q <= (height_q == DIM_W'(1));
			end
			if (ph_go)
				phantom_q <= 1'b0;
			if (drn_go)
				drain_q <= drain_q - DIM_W'(1);
		end
	end

endmodule

// ===== design/bblur_lines.sv =====
// Two line stores held as one {upper, middle} memory, read then rewritten per step.
// Forwards the pending write on back-to-back steps at one column. Depends on bblur_pkg.
`timescale 1ns / 1ps
module bblur_lines import bblur_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  issue_t  iss,
	output issue_t  iss_s1,
	output column_t column
);

	logic [2*RGB_W-1:0] mem [MAX_WIDTH];
	logic [2*RGB_W-1:0] rd_s1, fwd_data_s1, pair, wr_data;
	logic               fwd_s1;

	assign pair          = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign column.upper  = pair[2*RGB_W-1:RGB_W];
	assign column.middle = pair[RGB_W-1:0];
	assign column.lower  = iss_s1.rgb;
	assign wr_data       = {column.middle, iss_s1.rgb};

	always_ff @(posedge clk) begin
		if (en && iss.adv)
			rd_s1 <= mem[iss.col];
		if (en && iss_s1.adv)
			mem[iss_s1.col] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (en)
			fwd_data_s1 <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			iss_s1 <= iss;
			fwd_s1 <= iss.adv && iss_s1.adv && (iss_s1.col == iss.col);
		end
	end

endmodule

// ===== design/bblur_window.sv =====
// Neighbour window of the last two columns plus the incoming one; masked channel sums.
// Depends on bblur_pkg.
`timescale 1ns / 1ps
module bblur_window import bblur_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  issue_t  iss_s1,
	input  column_t column,
	output sums_t   sums_s2
);

	rgb_t             prev2_q [3];
	rgb_t             prev1_q [3];
	rgb_t             incoming [3];
	rgb_t             pix;
	logic [SUM_W-1:0] red_sum, green_sum, blue_sum;

	assign incoming[0] = column.upper;
	assign incoming[1] = column.middle;
	assign incoming[2] = column.lower;

	always_comb begin
		red_sum   = '0;
		green_sum = '0;
		blue_sum  = '0;
		pix       = '0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				case (j)
					0:       pix = prev2_q[k];
					1:       pix = prev1_q[k];
					default: pix = incoming[k];
				endcase
				if (iss_s1.row_mask[k] && iss_s1.col_mask[j]) begin
					red_sum   = red_sum   + SUM_W'(pix[23:16]);
					green_sum = green_sum + SUM_W'(pix[15:8]);
					blue_sum  = blue_sum  + SUM_W'(pix[7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				prev2_q[k] <= '0;
				prev1_q[k] <= '0;
			end
			sums_s2 <= '0;
		end else if (en) begin
			if (iss_s1.adv) begin
				for (int k = 0; k < 3; k++) begin
					prev2_q[k] <= prev1_q[k];
					prev1_q[k] <= incoming[k];
				end
			end
			sums_s2.valid <= iss_s1.adv && iss_s1.emit;
			sums_s2.eof   <= iss_s1.eof;
			sums_s2.red   <= red_sum;
			sums_s2.green <= green_sum;
			sums_s2.blue  <= blue_sum;
		end
	end

endmodule

// ===== design/bblur_out.sv =====
// Divide-by-nine, output register and skid stage of the box blur.
// Depends on bblur_pkg.
`timescale 1ns / 1ps
module bblur_out import bblur_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sums_t       sums_s2,
	output logic        en,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] pixel_out,
	output logic        end_of_frame
);

	logic        skid_v_q, push;
	logic [31:0] push_pix, skid_pix_q;
	logic        skid_eof_q;

	assign en       = !skid_v_q;
	assign push     = en && sums_s2.valid;
	assign push_pix = {div9(sums_s2.red), div9(sums_s2.green), div9(sums_s2.blue), ALPHA};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_v_q     <= 1'b0;
		end else if (!result_valid || !result_stall) begin
			result_valid <= skid_v_q || push;
			skid_v_q     <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!result_valid || !result_stall) begin
			if (skid_v_q) begin
				pixel_out    <= skid_pix_q;
				end_of_frame <= skid_eof_q;
			end else if (push) begin
				pixel_out    <= push_pix;
				end_of_frame <= sums_s2.eof;
			end
		end else if (push) begin
			skid_pix_q <= push_pix;
			skid_eof_q <= sums_s2.eof;
		end
	end

endmodule

// ===== design/box_blur_3x3_rgba_top.sv =====
// Between a beat and its result lie the step, window-sum and output registers.
// Throughput: one beat per cycle unless the output stalls; a one-row frame takes
// an extra step over an empty position after its last pixel, with beats stalled.
// Reset (arst_n, async): frame size 800x600, position and drain count cleared,
// window cleared; the line stores are not cleared.
`timescale 1ns / 1ps
`include "box_blur_3x3_rgba_top_macros.svh"
module box_blur_3x3_rgba_top import bblur_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 command,
	input  logic [31:0]          pixel_in,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [31:0]          pixel_out,
	output logic                 end_of_frame,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic    en;
	issue_t  iss, iss_s1;
	column_t column;
	sums_t   sums_s2;

	bblur_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.command    (command),
		.pixel_in   (pixel_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.iss        (iss)
	);

	bblur_lines u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.iss    (iss),
		.iss_s1 (iss_s1),
		.column (column)
	);

	bblur_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.iss_s1  (iss_s1),
		.column  (column),
		.sums_s2 (sums_s2)
	);

	bblur_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.sums_s2      (sums_s2),
		.en           (en),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_out    (pixel_out),
		.end_of_frame (end_of_frame)
	);

	`BBLUR_HOLDS(a_skid_behind_main, !en, result_valid, "skid holds a beat while output empty")
	`BBLUR_HOLDS(a_skid_cause, !en && $past(en), $past(result_valid && result_stall), "skid filled without a stall")
	`BBLUR_HOLDS(a_eof_emits, iss.eof, iss.adv && iss.emit, "frame end step gives no pixel")
	`BBLUR_NEXT(a_push_shows, en && sums_s2.valid, result_valid, "finished pixel lost")

endmodule
